### design/fpsc_pkg.sv
// Shared constants, codes and types of the frame pacing sleep controller.
package fpsc_pkg;

    localparam int TIME_WIDTH_DEF  = 32;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int SLEEP_LIMIT_DEF = 160;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int PERIOD_WIDTH     = 20;
    localparam int LEVEL_WIDTH      = 9;
    localparam int REQUEST_WIDTH    = 8;
    localparam int STAMP_WIDTH      = 32;
    localparam int FRAME_TIME_WIDTH = 32;
    localparam int DELTA_WIDTH      = 12;
    localparam int MAX_TIME_WIDTH   = 64;
    localparam int MAX_COUNT_WIDTH  = 32;

    localparam int PADDR_WIDTH = 2;
    localparam int PDATA_WIDTH = 32;
    localparam logic [PADDR_WIDTH-1:0] ADDR_TARGET_PERIOD = 2'd0;
    localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 20'd16666;

    localparam int ONE_SECOND_US   = 1000000;
    localparam int MS_US           = 1000;
    localparam int HALF_MS_US      = 500;
    localparam int HALF_PERIOD_DIV = 2000;
    localparam int DELTA_SAT       = 1023;

    // Division by 2000 is a shift by 4 and then by 125; division by 1000 is a
    // shift by 3 and then by 125. Each division by 125 is a reciprocal multiply
    // whose error stays below one unit for the input range it sees.
    localparam int HALF_PRE_SHIFT = 4;
    localparam int MS_PRE_SHIFT   = 3;
    localparam int CORR_NUM_WIDTH = 21;
    localparam int RECIP_HALF     = 67109;
    localparam int RECIP_HALF_W   = 17;
    localparam int RECIP_HALF_SH  = 23;
    localparam int RECIP_MS       = 268436;
    localparam int RECIP_MS_W     = 19;
    localparam int RECIP_MS_SH    = 25;

    typedef enum logic {
        REQ_TICK    = 1'b0,
        REQ_RESTART = 1'b1
    } req_type_t;

    // One classified word handed from the front part to the back part.
    typedef struct packed {
        req_type_t                    kind;
        logic                         window_done;
        logic                         slow;
        logic [MAX_TIME_WIDTH-1:0]    elapsed;
        logic [MAX_COUNT_WIDTH-1:0]   frames;
        logic [FRAME_TIME_WIDTH-1:0]  frame_time;
    } fpsc_cmd_t;

endpackage

### design/fpsc_if.sv
// Handshake interfaces for the input word and the result word.
interface fpsc_item_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  req_type;
    logic [fpsc_pkg::STAMP_WIDTH-1:0]      now_us;

    modport source (output valid, output req_type, output now_us, input ready);
    modport sink (input valid, input req_type, input now_us, output ready);
endinterface

interface fpsc_result_if;
    logic                                      valid;
    logic                                      ready;
    logic [fpsc_pkg::REQUEST_WIDTH-1:0]        sleep_request_ms;
    logic signed [fpsc_pkg::LEVEL_WIDTH-1:0]   sleep_level;
    logic [fpsc_pkg::FRAME_TIME_WIDTH-1:0]     frame_time_us;

    modport source (output valid, output sleep_request_ms, output sleep_level,
                    output frame_time_us, input ready);
    modport sink (input valid, input sleep_request_ms, input sleep_level,
                  input frame_time_us, output ready);
endinterface

### design/frame_pacing_sleep_controller_unit.sv
// Top level of the frame pacing sleep controller: register port and part wiring.
//
//  Port      Kind            Word
//  item      valid/ready in  req_type, now_us
//  result    valid/ready out sleep_request_ms, sleep_level, frame_time_us
//  p*        APB             target_period_us at byte address 0
//
// In the back part a plain tick goes through S_APPLY and a restart through S_HALF,
// both then through S_EMIT. A tick that closes a one second window first waits in
// S_AVG on the serial divider for the window average, one quotient bit per cycle,
// then S_CORR where needed. Rounding to ms and the restart level are reciprocal
// multiplies. While the queue is not full, the front part accepts words into it
// as the back part works or the result register waits. Reset clears all control
// state and loads the period register with 16666; no clearing pass is needed.
module frame_pacing_sleep_controller_unit #(
    parameter int TIME_WIDTH  = fpsc_pkg::TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = fpsc_pkg::COUNT_WIDTH_DEF,
    parameter int SLEEP_LIMIT = fpsc_pkg::SLEEP_LIMIT_DEF,
    parameter int QUEUE_DEPTH = fpsc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    fpsc_item_if.sink                           item,
    fpsc_result_if.source                       result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fpsc_pkg::PADDR_WIDTH-1:0]    paddr,
    input  logic [fpsc_pkg::PDATA_WIDTH-1:0]    pwdata,
    output logic [fpsc_pkg::PDATA_WIDTH-1:0]    prdata,
    output logic                                pready
);

    localparam int WIDE_W    = (TIME_WIDTH > COUNT_WIDTH) ? TIME_WIDTH : COUNT_WIDTH;
    localparam int DIV_WIDTH = (WIDE_W > 21) ? WIDE_W : 21;

    logic [fpsc_pkg::PERIOD_WIDTH-1:0] period_reg;
    logic                              period_sel;

    fpsc_pkg::fpsc_cmd_t  front_cmd, back_cmd;
    logic                 q_push, q_pop, q_full, q_empty;
    logic                 div_start, div_done;
    logic [DIV_WIDTH-1:0] div_dividend, div_divisor, div_quotient;

    assign period_sel = (paddr == fpsc_pkg::ADDR_TARGET_PERIOD);
    assign pready     = 1'b1;
    assign prdata     = period_sel ? fpsc_pkg::PDATA_WIDTH'(period_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            period_reg <= fpsc_pkg::PERIOD_RESET;
        else if (psel && penable && pwrite && period_sel)
            period_reg <= pwdata[fpsc_pkg::PERIOD_WIDTH-1:0];
    end

    fpsc_front #(
        .TIME_WIDTH  (TIME_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .target_period (period_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .cmd           (front_cmd)
    );

    fpsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .data_in  (front_cmd),
        .pop      (q_pop),
        .data_out (back_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    fpsc_div #(
        .WIDTH (DIV_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    fpsc_back #(
        .TIME_WIDTH  (TIME_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH),
        .SLEEP_LIMIT (SLEEP_LIMIT),
        .DIV_WIDTH   (DIV_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .target_period (period_reg),
        .q_empty       (q_empty),
        .cmd           (back_cmd),
        .q_pop         (q_pop),
        .div_start     (div_start),
        .div_dividend  (div_dividend),
        .div_divisor   (div_divisor),
        .div_done      (div_done),
        .div_quotient  (div_quotient),
        .result        (result)
    );

endmodule

### design/fpsc_front.sv
// Front part: accepts words, keeps the stamps and frame count, classifies each word.
module fpsc_front #(
    parameter int TIME_WIDTH  = fpsc_pkg::TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = fpsc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    fpsc_item_if.sink                             item,
    input  logic [fpsc_pkg::PERIOD_WIDTH-1:0]     target_period,
    input  logic                                  q_full,
    output logic                                  q_push,
    output fpsc_pkg::fpsc_cmd_t                   cmd
);

    logic [TIME_WIDTH-1:0]  last_stamp_reg, last_stamp_next;
    logic [TIME_WIDTH-1:0]  win_start_reg, win_start_next;
    logic [COUNT_WIDTH-1:0] frames_reg, frames_next;

    logic [TIME_WIDTH-1:0]  now_t;
    logic [TIME_WIDTH-1:0]  period_t;
    logic [TIME_WIDTH-1:0]  frame_dt;
    logic [TIME_WIDTH-1:0]  elapsed;
    logic [TIME_WIDTH-1:0]  lft;
    logic [COUNT_WIDTH-1:0] frames_inc;
    logic                   restart;
    logic                   win_done;

    always_comb
    begin
        now_t      = TIME_WIDTH'(item.now_us);
        period_t   = TIME_WIDTH'(target_period);
        frame_dt   = now_t - last_stamp_reg;
        elapsed    = now_t - win_start_reg;
        frames_inc = (frames_reg == '1) ? frames_reg : frames_reg + 1'b1;
        restart    = (item.req_type == fpsc_pkg::REQ_RESTART);
        win_done   = !restart && (elapsed >= TIME_WIDTH'(fpsc_pkg::ONE_SECOND_US));
        lft        = restart ? period_t : frame_dt;

        last_stamp_next = now_t;
        win_start_next  = (restart || win_done) ? now_t : win_start_reg;
        frames_next     = (restart || win_done) ? '0 : frames_inc;

        cmd.kind        = restart ? fpsc_pkg::REQ_RESTART : fpsc_pkg::REQ_TICK;
        cmd.window_done = win_done;
        cmd.slow        = (lft >= period_t);
        cmd.elapsed     = fpsc_pkg::MAX_TIME_WIDTH'(elapsed);
        cmd.frames      = fpsc_pkg::MAX_COUNT_WIDTH'(frames_inc);
        cmd.frame_time  = (lft != '0) ? fpsc_pkg::FRAME_TIME_WIDTH'(lft)
                                      : fpsc_pkg::FRAME_TIME_WIDTH'(target_period);
    end

    assign item.ready = !q_full;
    assign q_push     = item.valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_stamp_reg <= '0;
            win_start_reg  <= '0;
            frames_reg     <= '0;
        end
        else if (q_push)
        begin
            last_stamp_reg <= last_stamp_next;
            win_start_reg  <= win_start_next;
            frames_reg     <= frames_next;
        end
    end

endmodule

### design/fpsc_queue.sv
// Short queue of classified words between the front and back parts.
module fpsc_queue #(
    parameter int DEPTH = fpsc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  fpsc_pkg::fpsc_cmd_t  data_in,
    input  logic                 pop,
    output fpsc_pkg::fpsc_cmd_t  data_out,
    output logic                 full,
    output logic                 empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fpsc_pkg::fpsc_cmd_t slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign data_out = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= data_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

### design/fpsc_div.sv
// Restoring serial divider, one quotient bit per cycle.
module fpsc_div #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] rem_reg, quo_reg, dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [WIDTH:0]   rem_sh;
    logic [WIDTH:0]   trial;

    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[WIDTH-1]};
        trial  = rem_sh - {1'b0, dsr_reg};
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // A borrow out of the trial subtraction means the quotient bit is zero.
            if (!trial[WIDTH])
            begin
                rem_reg <= trial[WIDTH-1:0];
                quo_reg <= {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[WIDTH-1:0];
                quo_reg <= {quo_reg[WIDTH-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### design/fpsc_back.sv
// Back part: window correction, sleep level update and the result register.
module fpsc_back #(
    parameter int TIME_WIDTH  = fpsc_pkg::TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = fpsc_pkg::COUNT_WIDTH_DEF,
    parameter int SLEEP_LIMIT = fpsc_pkg::SLEEP_LIMIT_DEF,
    parameter int DIV_WIDTH   = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [fpsc_pkg::PERIOD_WIDTH-1:0]   target_period,
    input  logic                                q_empty,
    input  fpsc_pkg::fpsc_cmd_t                 cmd,
    output logic                                q_pop,
    output logic                                div_start,
    output logic [DIV_WIDTH-1:0]                div_dividend,
    output logic [DIV_WIDTH-1:0]                div_divisor,
    input  logic                                div_done,
    input  logic [DIV_WIDTH-1:0]                div_quotient,
    fpsc_result_if.source                       result
);

    localparam int LW = fpsc_pkg::LEVEL_WIDTH;
    localparam int DW = fpsc_pkg::DELTA_WIDTH;
    localparam int WW = DW + 1;
    localparam logic signed [LW-1:0] LIM_L  = LW'(SLEEP_LIMIT);
    localparam logic signed [LW-1:0] NLIM_L = -LIM_L;
    localparam logic signed [WW-1:0] LIM_W  = WW'(SLEEP_LIMIT);
    localparam logic signed [WW-1:0] NLIM_W = -LIM_W;

    localparam int HALF_IN_W   = fpsc_pkg::PERIOD_WIDTH - fpsc_pkg::HALF_PRE_SHIFT;
    localparam int HALF_PROD_W = HALF_IN_W + fpsc_pkg::RECIP_HALF_W;
    localparam int HALF_Q_W    = HALF_PROD_W - fpsc_pkg::RECIP_HALF_SH;
    localparam int MS_IN_W     = fpsc_pkg::CORR_NUM_WIDTH - fpsc_pkg::MS_PRE_SHIFT;
    localparam int MS_PROD_W   = MS_IN_W + fpsc_pkg::RECIP_MS_W;
    localparam int MS_Q_W      = MS_PROD_W - fpsc_pkg::RECIP_MS_SH;
    localparam logic [fpsc_pkg::RECIP_HALF_W-1:0] RECIP_HALF_L =
        fpsc_pkg::RECIP_HALF_W'(fpsc_pkg::RECIP_HALF);
    localparam logic [fpsc_pkg::RECIP_MS_W-1:0] RECIP_MS_L =
        fpsc_pkg::RECIP_MS_W'(fpsc_pkg::RECIP_MS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_AVG,
        S_CORR,
        S_HALF,
        S_APPLY,
        S_EMIT
    } state_t;

    state_t                                  state_reg;
    fpsc_pkg::fpsc_cmd_t                     cmd_reg;
    logic signed [LW-1:0]                    level_reg;
    logic signed [DW-1:0]                    delta_reg;
    logic                                    corr_neg_reg;
    logic                                    div_start_reg;
    logic [DIV_WIDTH-1:0]                    dividend_reg, divisor_reg;
    logic                                    out_valid_reg;
    logic [fpsc_pkg::REQUEST_WIDTH-1:0]      out_request_reg;
    logic signed [LW-1:0]                    out_level_reg;
    logic [fpsc_pkg::FRAME_TIME_WIDTH-1:0]   out_frame_time_reg;

    logic [DIV_WIDTH-1:0]  period_d;
    logic                  avg_over;
    logic [DIV_WIDTH-1:0]  diff_pos, diff_neg, corr_num;
    logic                  diff_sat, diff_small;
    logic [HALF_IN_W-1:0]  half_in;
    logic [HALF_PROD_W-1:0] half_prod;
    logic [HALF_Q_W-1:0]   half_q;
    logic [MS_IN_W-1:0]    ms_in;
    logic [MS_PROD_W-1:0]  ms_prod;
    logic [MS_Q_W-1:0]     ms_q;
    logic signed [DW-1:0]  delta_q;
    logic signed [LW-1:0]  half_level;
    logic signed [WW-1:0]  lvl_wide;
    logic signed [LW-1:0]  lvl_clamp, lvl_step;
    logic                  out_free;

    always_comb
    begin
        period_d   = DIV_WIDTH'(target_period);
        avg_over   = (div_quotient >= period_d);
        diff_pos   = div_quotient - period_d;
        diff_neg   = period_d - div_quotient;
        diff_sat   = (diff_pos > DIV_WIDTH'(fpsc_pkg::DELTA_SAT * fpsc_pkg::MS_US));
        diff_small = (diff_neg <= DIV_WIDTH'(fpsc_pkg::HALF_MS_US));
        // Round half up for a positive difference; a negative one rounds its magnitude half down.
        corr_num   = avg_over ? diff_pos + DIV_WIDTH'(fpsc_pkg::HALF_MS_US)
                              : diff_neg + DIV_WIDTH'(fpsc_pkg::HALF_MS_US - 1);

        // The rounded numerator held in dividend_reg is below 2^21 here.
        ms_in   = dividend_reg[fpsc_pkg::CORR_NUM_WIDTH-1:fpsc_pkg::MS_PRE_SHIFT];
        ms_prod = ms_in * RECIP_MS_L;
        ms_q    = ms_prod[MS_PROD_W-1:fpsc_pkg::RECIP_MS_SH];
        delta_q = corr_neg_reg ? $signed(DW'(~ms_q + 1'b1)) : $signed(DW'(ms_q));

        half_in    = target_period[fpsc_pkg::PERIOD_WIDTH-1:fpsc_pkg::HALF_PRE_SHIFT];
        half_prod  = half_in * RECIP_HALF_L;
        half_q     = half_prod[HALF_PROD_W-1:fpsc_pkg::RECIP_HALF_SH];
        half_level = (half_q > HALF_Q_W'(SLEEP_LIMIT)) ? LIM_L : half_q[LW-1:0];

        lvl_wide = $signed({{(WW - LW){level_reg[LW-1]}}, level_reg})
                 - $signed({delta_reg[DW-1], delta_reg});
        if (lvl_wide > LIM_W)
            lvl_clamp = LIM_L;
        else if (lvl_wide < NLIM_W)
            lvl_clamp = NLIM_L;
        else
            lvl_clamp = lvl_wide[LW-1:0];

        if (cmd_reg.slow)
            lvl_step = (lvl_clamp > NLIM_L) ? lvl_clamp - 9'sd1 : lvl_clamp;
        else
            lvl_step = (lvl_clamp < LIM_L) ? lvl_clamp + 9'sd1 : lvl_clamp;

        out_free = !out_valid_reg || result.ready;
    end

    assign q_pop = (state_reg == S_IDLE) && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            level_reg     <= '0;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (out_valid_reg && result.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        cmd_reg   <= cmd;
                        delta_reg <= '0;
                        if (cmd.kind == fpsc_pkg::REQ_RESTART)
                        begin
                            state_reg <= S_HALF;
                        end
                        else if (cmd.window_done)
                        begin
                            dividend_reg  <= DIV_WIDTH'(cmd.elapsed[TIME_WIDTH-1:0]);
                            divisor_reg   <= DIV_WIDTH'(cmd.frames[COUNT_WIDTH-1:0]);
                            div_start_reg <= 1'b1;
                            state_reg     <= S_AVG;
                        end
                        else
                        begin
                            state_reg <= S_APPLY;
                        end
                    end
                end
                S_AVG:
                begin
                    if (div_done)
                    begin
                        if (avg_over && diff_sat)
                        begin
                            delta_reg <= DW'(fpsc_pkg::DELTA_SAT);
                            state_reg <= S_APPLY;
                        end
                        else if (!avg_over && diff_small)
                        begin
                            state_reg <= S_APPLY;
                        end
                        else
                        begin
                            corr_neg_reg <= !avg_over;
                            dividend_reg <= corr_num;
                            state_reg    <= S_CORR;
                        end
                    end
                end
                S_CORR:
                begin
                    delta_reg <= delta_q;
                    state_reg <= S_APPLY;
                end
                S_HALF:
                begin
                    level_reg <= half_level;
                    state_reg <= S_EMIT;
                end
                S_APPLY:
                begin
                    level_reg <= lvl_step;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg      <= 1'b1;
                        out_level_reg      <= level_reg;
                        out_request_reg    <= (level_reg > 0) ? level_reg[7:0] : '0;
                        out_frame_time_reg <= cmd_reg.frame_time;
                        state_reg          <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign div_start              = div_start_reg;
    assign div_dividend           = dividend_reg;
    assign div_divisor            = divisor_reg;
    assign result.valid           = out_valid_reg;
    assign result.sleep_request_ms = out_request_reg;
    assign result.sleep_level     = out_level_reg;
    assign result.frame_time_us   = out_frame_time_reg;

    a_div_start_waits: assert property (@(posedge clk) disable iff (!rst_n)
        div_start_reg |-> (state_reg == S_AVG))
        else $error("divider started while the back part does not wait for it");

    a_div_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_AVG))
        else $error("divider finished while the back part does not wait for it");

    a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg != S_IDLE))
        else $error("back part stayed idle after taking a word from the queue");

    a_request_matches_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_request_reg == ((out_level_reg > 0) ? out_level_reg[7:0] : 8'd0)))
        else $error("sleep request does not match the positive part of the level");

endmodule

### tb/tb_top.sv
// Self-checking testbench of the frame pacing sleep controller with its own pacing predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT      = 1_000_000;
    localparam int     FRAME_COUNT_MAX  = (1 << fpsc_pkg::COUNT_WIDTH_DEF) - 1;
    localparam int     SETTLE_CYCLES    = 80;
    localparam int     HOLD_OFF_CYCLES  = 500;
    localparam int     RANDOM_PER_PHASE = 475;
    localparam int     REPORT_MAX       = 100;

    typedef struct packed {
        logic [fpsc_pkg::REQUEST_WIDTH-1:0]    request_ms;
        logic [fpsc_pkg::LEVEL_WIDTH-1:0]      level;
        logic [fpsc_pkg::FRAME_TIME_WIDTH-1:0] frame_time;
    } pacing_word_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [fpsc_pkg::PADDR_WIDTH-1:0] paddr;
    logic [fpsc_pkg::PDATA_WIDTH-1:0] pwdata;
    logic [fpsc_pkg::PDATA_WIDTH-1:0] prdata;
    logic                             pready;

    fpsc_item_if   frame_in ();
    fpsc_result_if pacing_out ();

    frame_pacing_sleep_controller_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (frame_in),
        .result  (pacing_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor copy of the pacing state and the period register.
    logic [fpsc_pkg::PERIOD_WIDTH-1:0]     target_period;
    logic [fpsc_pkg::STAMP_WIDTH-1:0]      last_stamp;
    logic [fpsc_pkg::STAMP_WIDTH-1:0]      window_start;
    logic [fpsc_pkg::COUNT_WIDTH_DEF-1:0]  frames_in_window;
    int                                    pace_level;
    logic [fpsc_pkg::FRAME_TIME_WIDTH-1:0] last_frame_time;

    pacing_word_t pending_pacing[$];
    int           send_idle_pct;
    int           stall_pct;
    logic         holding;
    int           mismatches;
    longint       cycle_count = 0;

    always #4 clk = ~clk;

    function automatic pacing_word_t predict_pacing(fpsc_pkg::req_type_t kind,
                                                    logic [fpsc_pkg::STAMP_WIDTH-1:0] now);
        logic [fpsc_pkg::STAMP_WIDTH-1:0] elapsed;
        longint                           avg;
        longint                           gap;
        int                               correction;
        pacing_word_t                     word;
        if (kind == fpsc_pkg::REQ_RESTART)
        begin
            frames_in_window = '0;
            last_stamp = now;
            window_start = now;
            last_frame_time = fpsc_pkg::FRAME_TIME_WIDTH'(target_period);
            if (target_period / fpsc_pkg::HALF_PERIOD_DIV > fpsc_pkg::SLEEP_LIMIT_DEF)
                pace_level = fpsc_pkg::SLEEP_LIMIT_DEF;
            else
                pace_level = int'(target_period / fpsc_pkg::HALF_PERIOD_DIV);
        end
        else
        begin
            last_frame_time = now - last_stamp;
            last_stamp = now;
            if (frames_in_window != FRAME_COUNT_MAX[fpsc_pkg::COUNT_WIDTH_DEF-1:0])
                frames_in_window++;
            elapsed = now - window_start;
            if (elapsed >= fpsc_pkg::ONE_SECOND_US)
            begin
                // The count is at least one here, since this tick was counted.
                avg = elapsed;
                avg = avg / longint'(frames_in_window);
                if (avg >= longint'(target_period))
                begin
                    gap = avg - longint'(target_period);
                    if (gap > fpsc_pkg::DELTA_SAT * fpsc_pkg::MS_US)
                        correction = fpsc_pkg::DELTA_SAT;
                    else
                        correction = int'((gap + fpsc_pkg::HALF_MS_US) / fpsc_pkg::MS_US);
                end
                else
                begin
                    gap = longint'(target_period) - avg;
                    if (gap <= fpsc_pkg::HALF_MS_US)
                        correction = 0;
                    else
                        correction = -int'((gap - fpsc_pkg::HALF_MS_US + fpsc_pkg::MS_US - 1)
                                           / fpsc_pkg::MS_US);
                end
                pace_level = pace_level - correction;
                if (pace_level > fpsc_pkg::SLEEP_LIMIT_DEF)
                    pace_level = fpsc_pkg::SLEEP_LIMIT_DEF;
                else if (pace_level < -fpsc_pkg::SLEEP_LIMIT_DEF)
                    pace_level = -fpsc_pkg::SLEEP_LIMIT_DEF;
                window_start = now;
                frames_in_window = '0;
            end
            if (last_frame_time >= target_period)
            begin
                if (pace_level > -fpsc_pkg::SLEEP_LIMIT_DEF)
                    pace_level--;
            end
            else if (pace_level < fpsc_pkg::SLEEP_LIMIT_DEF)
                pace_level++;
        end
        word.request_ms = (pace_level > 0) ? fpsc_pkg::REQUEST_WIDTH'(pace_level) : '0;
        word.level = fpsc_pkg::LEVEL_WIDTH'(pace_level);
        word.frame_time = (last_frame_time != 0) ? last_frame_time
                                                 : fpsc_pkg::FRAME_TIME_WIDTH'(target_period);
        return word;
    endfunction

    task automatic send_word(fpsc_pkg::req_type_t kind, logic [fpsc_pkg::STAMP_WIDTH-1:0] now);
        while ($urandom_range(99) < send_idle_pct)
        begin
            frame_in.valid <= 1'b0;
            @(posedge clk);
        end
        frame_in.valid    <= 1'b1;
        frame_in.req_type <= kind;
        frame_in.now_us   <= now;
        @(posedge clk);
        while (!frame_in.ready)
            @(posedge clk);
        pending_pacing.push_back(predict_pacing(kind, now));
    endtask

    task automatic wait_results_done();
        frame_in.valid <= 1'b0;
        while (pending_pacing.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The register is only touched once the block has gone quiet.
    task automatic set_target_period(logic [fpsc_pkg::PERIOD_WIDTH-1:0] value);
        logic [fpsc_pkg::PDATA_WIDTH-1:0] filler;
        wait_results_done();
        filler = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= fpsc_pkg::ADDR_TARGET_PERIOD;
        pwdata  <= {filler[fpsc_pkg::PDATA_WIDTH-1:fpsc_pkg::PERIOD_WIDTH], value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        target_period = value;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_directed_cases();
        // Reset period: a zero frame time reports the period, then exact, fast and slow frames.
        send_word(fpsc_pkg::REQ_TICK, 32'd0);
        send_word(fpsc_pkg::REQ_TICK, 32'd16666);
        send_word(fpsc_pkg::REQ_TICK, 32'd26666);
        send_word(fpsc_pkg::REQ_TICK, 32'd1_200_000);
        // Timestamp wrap, repeated stamp and a stamp going backwards.
        send_word(fpsc_pkg::REQ_RESTART, 32'hFFFF_FFF0);
        send_word(fpsc_pkg::REQ_TICK, 32'hFFFF_FFFF);
        send_word(fpsc_pkg::REQ_TICK, 32'h0000_0010);
        send_word(fpsc_pkg::REQ_TICK, 32'h0000_0010);
        send_word(fpsc_pkg::REQ_TICK, 32'h0000_0008);
        // Zero period: every frame counts as slow.
        set_target_period('0);
        send_word(fpsc_pkg::REQ_TICK, 32'd9);
        send_word(fpsc_pkg::REQ_RESTART, 32'd9);
        // Largest period: restart level saturates, then both clamps are hit.
        set_target_period('1);
        send_word(fpsc_pkg::REQ_RESTART, 32'd5);
        send_word(fpsc_pkg::REQ_TICK, 32'd6);
        send_word(fpsc_pkg::REQ_TICK, 32'd3_000_005);
        send_word(fpsc_pkg::REQ_RESTART, 32'd0);
        send_word(fpsc_pkg::REQ_TICK, 32'd1000);
        send_word(fpsc_pkg::REQ_TICK, 32'd1_000_000);
        // A huge average saturates the correction.
        set_target_period(20'd1000);
        send_word(fpsc_pkg::REQ_RESTART, 32'd0);
        send_word(fpsc_pkg::REQ_TICK, 32'h8000_0000);
        // Rounding edges of the correction.
        set_target_period(20'd999_500);
        send_word(fpsc_pkg::REQ_RESTART, 32'd0);
        send_word(fpsc_pkg::REQ_TICK, 32'd1_000_000);
        set_target_period(20'd999_501);
        send_word(fpsc_pkg::REQ_RESTART, 32'd0);
        send_word(fpsc_pkg::REQ_TICK, 32'd1_000_000);
        set_target_period(20'd1_000_500);
        send_word(fpsc_pkg::REQ_TICK, 32'd4_000_000_000);
        send_word(fpsc_pkg::REQ_TICK, 32'd4_001_000_000);
        set_target_period(20'd1_000_501);
        send_word(fpsc_pkg::REQ_TICK, 32'd4_003_000_000);
        send_word(fpsc_pkg::REQ_TICK, 32'd4_004_000_000);
    endtask

    task automatic test_stalled_receiver();
        logic [fpsc_pkg::STAMP_WIDTH-1:0] stamp;
        set_target_period(fpsc_pkg::PERIOD_RESET);
        stamp = $urandom;
        send_word(fpsc_pkg::REQ_RESTART, stamp);
        fork
            begin
                holding <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                holding <= 1'b0;
            end
        join_none
        repeat (30)
        begin
            stamp = stamp + $urandom_range(80_000, 5_000);
            send_word(fpsc_pkg::REQ_TICK, stamp);
        end
        // The sender now waits for every result before it goes on.
        wait_results_done();
        repeat (10)
        begin
            stamp = stamp + $urandom_range(80_000, 5_000);
            send_word(fpsc_pkg::REQ_TICK, stamp);
        end
    endtask

    // Runs of ticks paced around the period, with noise, jumps back and restarts mixed in.
    task automatic test_random_pacing(int word_count);
        int                                sent;
        int                                ratio;
        int                                run;
        longint                            step;
        logic [fpsc_pkg::PERIOD_WIDTH-1:0] period;
        logic [fpsc_pkg::STAMP_WIDTH-1:0]  stamp;
        fpsc_pkg::req_type_t               kind;
        sent = 0;
        period = target_period;
        stamp = $urandom;
        while (sent < word_count)
        begin
            if ($urandom_range(1) == 1)
            begin
                case ($urandom_range(9))
                    0: period = fpsc_pkg::PERIOD_WIDTH'($urandom);
                    1:
                    begin
                        case ($urandom_range(3))
                            0:       period = '0;
                            1:       period = 20'd1000;
                            2:       period = 20'd1_000_000;
                            default: period = '1;
                        endcase
                    end
                    2, 3, 4: period = fpsc_pkg::PERIOD_WIDTH'($urandom_range(20_000, 1_000));
                    default: period = fpsc_pkg::PERIOD_WIDTH'($urandom_range(300_000, 20_000));
                endcase
                set_target_period(period);
            end
            send_word(fpsc_pkg::REQ_RESTART, stamp);
            sent++;
            ratio = $urandom_range(40, 6);
            run = $urandom_range(60, 10);
            repeat (run)
            begin
                kind = fpsc_pkg::REQ_TICK;
                case ($urandom_range(19))
                    0: stamp = $urandom;
                    1: stamp = stamp - $urandom_range(5_000, 1);
                    2: ;
                    3: kind = fpsc_pkg::REQ_RESTART;
                    default:
                    begin
                        step = longint'(period) * ratio / 16
                               + longint'($urandom_range(period / 8, 0))
                               - longint'(period / 16);
                        if (step < 0)
                            step = 0;
                        stamp = stamp + fpsc_pkg::STAMP_WIDTH'(step);
                    end
                endcase
                send_word(kind, stamp);
                sent++;
            end
        end
    endtask

    always @(posedge clk)
        pacing_out.ready <= !holding && ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin : check_pacing
        pacing_word_t want;
        pacing_word_t got;
        if (rst_n && pacing_out.valid && pacing_out.ready)
        begin
            got = {pacing_out.sleep_request_ms, pacing_out.sleep_level,
                   pacing_out.frame_time_us};
            if (pending_pacing.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: word with none expected:", $time,
                             " actual req %0d level %0d frame %0d",
                             got.request_ms, $signed(got.level), got.frame_time);
            end
            else
            begin
                want = pending_pacing.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: expected req %0d level %0d frame %0d,", $time,
                                 want.request_ms, $signed(want.level), want.frame_time,
                                 " actual req %0d level %0d frame %0d",
                                 got.request_ms, $signed(got.level), got.frame_time);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        frame_in.valid = 1'b0;
        frame_in.req_type = fpsc_pkg::REQ_TICK;
        frame_in.now_us = '0;
        pacing_out.ready = 1'b0;
        holding = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        mismatches = 0;
        target_period = fpsc_pkg::PERIOD_RESET;
        last_stamp = '0;
        window_start = '0;
        frames_in_window = '0;
        pace_level = 0;
        last_frame_time = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_stalled_receiver();

        send_idle_pct = 0;
        stall_pct = 0;
        test_random_pacing(RANDOM_PER_PHASE);
        send_idle_pct = 75;
        stall_pct = 0;
        test_random_pacing(RANDOM_PER_PHASE);
        send_idle_pct = 0;
        stall_pct = 75;
        test_random_pacing(RANDOM_PER_PHASE);
        send_idle_pct = 6;
        stall_pct = 6;
        test_random_pacing(RANDOM_PER_PHASE);

        wait_results_done();
        if (mismatches == 0 && pending_pacing.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

### files.f
design/fpsc_pkg.sv
design/fpsc_if.sv
design/fpsc_front.sv
design/fpsc_queue.sv
design/fpsc_div.sv
design/fpsc_back.sv
design/frame_pacing_sleep_controller_unit.sv
tb/tb_top.sv
